// ----- src/ssvf_pkg.sv -----
// Shared types, codes and helpers for the stereo state variable filter.
// No dependencies; every other file in src/ but ssvf_checker refers to it by scoped names.
package ssvf_pkg;

	localparam int LANES = 2;
	localparam int REG_W = 24;
	localparam int WGT_W = 24;
	localparam int INT_W = 32;
	localparam int MUL_B_W = 34;
	localparam int PROD_W = REG_W + MUL_B_W;
	localparam int ACC_W = PROD_W + 2;
	localparam int RND_W = ACC_W + 1;
	localparam int STEP_W = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [STEP_W-1:0] WGT_LAST = 4'd9;
	localparam logic [STEP_W-1:0] FILT_LAST = 4'd8;

	typedef enum logic [2:0] {
		REG_BYPASS,
		REG_MODE,
		REG_COEF_A1,
		REG_COEF_A2,
		REG_COEF_A3,
		REG_DAMPING,
		REG_AMPLITUDE
	} reg_idx_t;

	typedef enum logic [3:0] {
		MODE_LOWPASS,
		MODE_BANDPASS,
		MODE_HIGHPASS,
		MODE_NOTCH,
		MODE_PEAK,
		MODE_ALLPASS,
		MODE_BELL,
		MODE_LOWSHELF,
		MODE_HIGHSHELF
	} mode_t;

	typedef enum logic [2:0] {
		A_COEF_A1,
		A_COEF_A2,
		A_COEF_A3,
		A_W0,
		A_W1,
		A_W2,
		A_AMP,
		A_DAMP
	} a_sel_t;

	typedef enum logic [2:0] {
		B_IC1,
		B_V3,
		B_V0,
		B_V1,
		B_V2,
		B_AMP,
		B_WX,
		B_T
	} b_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [2:0] {
		WB_NONE,
		WB_V1,
		WB_V2,
		WB_Y,
		WB_AA,
		WB_T,
		WB_U
	} wb_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		wb_t     wb;
	} mac_cmd_t;

	typedef struct packed {
		mac_cmd_t mac;
		logic     load_in;
		logic     load_out;
		logic     commit_wgt;
	} dp_cmd_t;

	typedef struct packed {
		logic bypass;
		logic cfg_write;
	} ctrl_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WGT,
		ST_FILT,
		ST_OUT
	} state_t;

	localparam mac_cmd_t MAC_IDLE = '{A_COEF_A1, B_IC1, ACC_HOLD, WB_NONE};

	// Clamp a signed value to a signed field of w bits.
	function automatic logic signed [63:0] sat_s(logic signed [63:0] v, int unsigned w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = ~hi;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// Mix weight schedule: A*A, then k times the mode operand, then A times that.
	function automatic mac_cmd_t wgt_cmd(logic [STEP_W-1:0] step);
		mac_cmd_t c;
		c = MAC_IDLE;
		case (step)
			4'd0: c = '{A_AMP, B_AMP, ACC_LOAD, WB_AA};
			4'd3: c = '{A_DAMP, B_WX, ACC_LOAD, WB_T};
			4'd6: c = '{A_AMP, B_T, ACC_LOAD, WB_U};
			default: c = MAC_IDLE;
		endcase
		return c;
	endfunction

	// Per-sample schedule: two node sums, then the output mix.
	function automatic mac_cmd_t filt_cmd(logic [STEP_W-1:0] step);
		mac_cmd_t c;
		c = MAC_IDLE;
		case (step)
			4'd0: c = '{A_COEF_A1, B_IC1, ACC_LOAD, WB_NONE};
			4'd1: c = '{A_COEF_A2, B_V3, ACC_ADD, WB_V1};
			4'd2: c = '{A_COEF_A2, B_IC1, ACC_LOAD, WB_NONE};
			4'd3: c = '{A_COEF_A3, B_V3, ACC_ADD, WB_V2};
			4'd4: c = '{A_W0, B_V0, ACC_LOAD, WB_NONE};
			4'd5: c = '{A_W1, B_V1, ACC_ADD, WB_NONE};
			4'd6: c = '{A_W2, B_V2, ACC_ADD, WB_Y};
			default: c = MAC_IDLE;
		endcase
		return c;
	endfunction

endpackage

// ----- src/ssvf_lane.sv -----
// One filter lane: multiply-accumulate unit, node registers and integrator state.
// Depends on ssvf_pkg.
module ssvf_lane #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_FRAC_BITS = 20
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ssvf_pkg::mac_cmd_t                     cmd,
	input  logic signed [ssvf_pkg::REG_W-1:0]      a_op,
	input  logic signed [ssvf_pkg::MUL_B_W-1:0]    ext_b,
	input  logic signed [SAMPLE_BITS-1:0]          v0,
	output logic signed [SAMPLE_BITS-1:0]          y,
	output logic signed [ssvf_pkg::RND_W-1:0]      res,
	output ssvf_pkg::wb_t                          res_wb
);

	localparam logic signed [ssvf_pkg::RND_W-1:0] HALF =
		ssvf_pkg::RND_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [ssvf_pkg::INT_W-1:0]   ic1_q, ic2_q, v1_q, v2_q;
	logic signed [SAMPLE_BITS-1:0]       y_q;
	logic signed [ssvf_pkg::INT_W:0]     v3;
	logic signed [ssvf_pkg::MUL_B_W-1:0] b_op;
	logic signed [ssvf_pkg::PROD_W-1:0]  prod_c, prod_s1;
	ssvf_pkg::acc_op_t                   acc_op_s1;
	ssvf_pkg::wb_t                       wb_s1, wb_s2;
	logic signed [ssvf_pkg::ACC_W-1:0]   acc_q;
	logic signed [ssvf_pkg::RND_W-1:0]   rnd_sum;
	logic signed [63:0]                  res64, ic1_64, ic2_64, v1_64, v2_64;

	assign v3 = (ssvf_pkg::INT_W + 1)'(v0) - (ssvf_pkg::INT_W + 1)'(ic2_q);

	always_comb begin
		case (cmd.b_sel)
			ssvf_pkg::B_IC1: b_op = ssvf_pkg::MUL_B_W'(ic1_q);
			ssvf_pkg::B_V3:  b_op = ssvf_pkg::MUL_B_W'(v3);
			ssvf_pkg::B_V0:  b_op = ssvf_pkg::MUL_B_W'(v0);
			ssvf_pkg::B_V1:  b_op = ssvf_pkg::MUL_B_W'(v1_q);
			ssvf_pkg::B_V2:  b_op = ssvf_pkg::MUL_B_W'(v2_q);
			default:         b_op = ext_b;
		endcase
	end

	assign prod_c = a_op * b_op;

	// round half up, then floor shift
	assign rnd_sum = {acc_q[ssvf_pkg::ACC_W-1], acc_q} + HALF;
	assign res = rnd_sum >>> COEF_FRAC_BITS;
	assign res64 = 64'(res);
	assign ic1_64 = 64'(ic1_q);
	assign ic2_64 = 64'(ic2_q);
	assign v1_64 = 64'(v1_q);
	assign v2_64 = 64'(v2_q);

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_op_s1 <= ssvf_pkg::ACC_HOLD;
			wb_s1 <= ssvf_pkg::WB_NONE;
			wb_s2 <= ssvf_pkg::WB_NONE;
		end else begin
			acc_op_s1 <= cmd.acc_op;
			wb_s1 <= cmd.wb;
			wb_s2 <= wb_s1;
		end
	end

	always_ff @(posedge clk) begin
		case (acc_op_s1)
			ssvf_pkg::ACC_LOAD: acc_q <= ssvf_pkg::ACC_W'(prod_s1);
			ssvf_pkg::ACC_ADD:  acc_q <= acc_q + ssvf_pkg::ACC_W'(prod_s1);
			default:            acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		case (wb_s2)
			ssvf_pkg::WB_V1: v1_q <= ssvf_pkg::INT_W'(ssvf_pkg::sat_s(res64, ssvf_pkg::INT_W));
			ssvf_pkg::WB_V2: v2_q <= ssvf_pkg::INT_W'(ssvf_pkg::sat_s(ic2_64 + res64,
				ssvf_pkg::INT_W));
			ssvf_pkg::WB_Y:  y_q <= SAMPLE_BITS'(ssvf_pkg::sat_s(res64, SAMPLE_BITS));
			default: begin
			end
		endcase
	end

	// advance the integrators once the output sum is final
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic1_q <= '0;
			ic2_q <= '0;
		end else if (wb_s2 == ssvf_pkg::WB_Y) begin
			ic1_q <= ssvf_pkg::INT_W'(ssvf_pkg::sat_s((v1_64 <<< 1) - ic1_64, ssvf_pkg::INT_W));
			ic2_q <= ssvf_pkg::INT_W'(ssvf_pkg::sat_s((v2_64 <<< 1) - ic2_64, ssvf_pkg::INT_W));
		end
	end

	assign y = y_q;
	assign res_wb = wb_s2;

endmodule

// ----- src/ssvf_datapath.sv -----
// Datapath: input and output words, mix weights, shared operands and the lanes.
// Depends on ssvf_pkg and ssvf_lane.
module ssvf_datapath #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_FRAC_BITS = 20,
	parameter int CHANNEL_COUNT = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ssvf_pkg::dp_cmd_t                  cmd,
	input  logic                               bypass,
	input  logic [3:0]                         mode,
	input  logic signed [ssvf_pkg::REG_W-1:0]  coef_a1,
	input  logic signed [ssvf_pkg::REG_W-1:0]  coef_a2,
	input  logic signed [ssvf_pkg::REG_W-1:0]  coef_a3,
	input  logic signed [ssvf_pkg::REG_W-1:0]  damping,
	input  logic signed [ssvf_pkg::REG_W-1:0]  amplitude,
	input  logic signed [SAMPLE_BITS-1:0]      left_in,
	input  logic signed [SAMPLE_BITS-1:0]      right_in,
	output logic signed [SAMPLE_BITS-1:0]      left_out,
	output logic signed [SAMPLE_BITS-1:0]      right_out
);

	localparam int STATE_LANES =
		(CHANNEL_COUNT < ssvf_pkg::LANES) ? CHANNEL_COUNT : ssvf_pkg::LANES;

	logic signed [SAMPLE_BITS-1:0]        in_q [ssvf_pkg::LANES];
	logic signed [SAMPLE_BITS-1:0]        out_q [ssvf_pkg::LANES];
	logic signed [SAMPLE_BITS-1:0]        y [ssvf_pkg::LANES];
	logic signed [ssvf_pkg::RND_W-1:0]    lane_res [STATE_LANES];
	ssvf_pkg::wb_t                        lane_wb [STATE_LANES];
	logic signed [ssvf_pkg::WGT_W-1:0]    m0_q, m1_q, m2_q, u_q;
	logic signed [ssvf_pkg::MUL_B_W-1:0]  aa_q, t_q, wx, ext_b;
	logic signed [ssvf_pkg::REG_W-1:0]    a_op;
	logic signed [63:0]                   one64, k64, a64, aa64, t64, u64, res64;
	logic signed [63:0]                   w0, w1, w2, wx64;

	assign one64 = 64'sd1 <<< COEF_FRAC_BITS;
	assign k64 = 64'(damping);
	assign a64 = 64'(amplitude);
	assign aa64 = 64'(aa_q);
	assign t64 = 64'(t_q);
	assign u64 = 64'(u_q);
	assign res64 = 64'(lane_res[0]);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q[0] <= left_in;
			in_q[1] <= right_in;
		end
	end

	always_comb begin
		case (cmd.mac.a_sel)
			ssvf_pkg::A_COEF_A1: a_op = coef_a1;
			ssvf_pkg::A_COEF_A2: a_op = coef_a2;
			ssvf_pkg::A_COEF_A3: a_op = coef_a3;
			ssvf_pkg::A_W0:      a_op = m0_q;
			ssvf_pkg::A_W1:      a_op = m1_q;
			ssvf_pkg::A_W2:      a_op = m2_q;
			ssvf_pkg::A_AMP:     a_op = amplitude;
			default:             a_op = damping;
		endcase
	end

	// operand that damping multiplies on the way to the middle weight
	always_comb begin
		case (ssvf_pkg::mode_t'(mode))
			ssvf_pkg::MODE_BELL:     wx64 = aa64 - one64;
			ssvf_pkg::MODE_LOWSHELF: wx64 = a64 - one64;
			default:                 wx64 = one64 - a64;
		endcase
	end
	assign wx = wx64[ssvf_pkg::MUL_B_W-1:0];

	always_comb begin
		case (cmd.mac.b_sel)
			ssvf_pkg::B_AMP: ext_b = ssvf_pkg::MUL_B_W'(amplitude);
			ssvf_pkg::B_WX:  ext_b = wx;
			ssvf_pkg::B_T:   ext_b = t_q;
			default:         ext_b = '0;
		endcase
	end

	for (genvar l = 0; l < ssvf_pkg::LANES; l++) begin : g_lane
		if (l < STATE_LANES) begin : g_filt
			ssvf_lane #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.COEF_FRAC_BITS(COEF_FRAC_BITS)
			) u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd.mac),
				.a_op(a_op),
				.ext_b(ext_b),
				.v0(in_q[l]),
				.y(y[l]),
				.res(lane_res[l]),
				.res_wb(lane_wb[l])
			);
		end else begin : g_thru
			assign y[l] = in_q[l];
		end
	end

	// weight intermediates come out of lane 0
	always_ff @(posedge clk) begin
		case (lane_wb[0])
			ssvf_pkg::WB_AA: aa_q <= res64[ssvf_pkg::MUL_B_W-1:0];
			ssvf_pkg::WB_T:  t_q <= ssvf_pkg::MUL_B_W'(ssvf_pkg::sat_s(res64, ssvf_pkg::MUL_B_W));
			ssvf_pkg::WB_U:  u_q <= ssvf_pkg::WGT_W'(ssvf_pkg::sat_s(res64, ssvf_pkg::WGT_W));
			default: begin
			end
		endcase
	end

	always_comb begin
		w0 = one64;
		w1 = '0;
		w2 = '0;
		case (ssvf_pkg::mode_t'(mode))
			ssvf_pkg::MODE_LOWPASS: begin
				w0 = '0;
				w2 = one64;
			end
			ssvf_pkg::MODE_BANDPASS: begin
				w0 = '0;
				w1 = one64;
			end
			ssvf_pkg::MODE_HIGHPASS: begin
				w1 = -k64;
				w2 = -one64;
			end
			ssvf_pkg::MODE_NOTCH: w1 = -k64;
			ssvf_pkg::MODE_PEAK: begin
				w1 = -k64;
				w2 = -(one64 <<< 1);
			end
			ssvf_pkg::MODE_ALLPASS: w1 = -(k64 <<< 1);
			ssvf_pkg::MODE_BELL: w1 = t64;
			ssvf_pkg::MODE_LOWSHELF: begin
				w1 = t64;
				w2 = aa64 - one64;
			end
			ssvf_pkg::MODE_HIGHSHELF: begin
				w0 = aa64;
				w1 = u64;
				w2 = one64 - aa64;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_wgt) begin
			m0_q <= ssvf_pkg::WGT_W'(ssvf_pkg::sat_s(w0, ssvf_pkg::WGT_W));
			m1_q <= ssvf_pkg::WGT_W'(ssvf_pkg::sat_s(w1, ssvf_pkg::WGT_W));
			m2_q <= ssvf_pkg::WGT_W'(ssvf_pkg::sat_s(w2, ssvf_pkg::WGT_W));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int l = 0; l < ssvf_pkg::LANES; l++) begin
				out_q[l] <= bypass ? in_q[l] : y[l];
			end
		end
	end

	assign left_out = out_q[0];
	assign right_out = out_q[1];

endmodule

// ----- src/ssvf_ctrl.sv -----
// Controller: sequences weight and filter steps and owns both handshakes.
// Depends on ssvf_pkg.
module ssvf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  ssvf_pkg::ctrl_status_t status,
	output ssvf_pkg::dp_cmd_t      cmd
);

	ssvf_pkg::state_t               state_q, state_d;
	logic [ssvf_pkg::STEP_W-1:0]    step_q;
	logic                           dirty_q;
	logic                           out_valid_q;
	logic                           out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssvf_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (status.bypass) begin
						state_d = ssvf_pkg::ST_OUT;
					end else if (dirty_q) begin
						state_d = ssvf_pkg::ST_WGT;
					end else begin
						state_d = ssvf_pkg::ST_FILT;
					end
				end
			end
			ssvf_pkg::ST_WGT: begin
				if (step_q == ssvf_pkg::WGT_LAST) begin
					state_d = ssvf_pkg::ST_FILT;
				end
			end
			ssvf_pkg::ST_FILT: begin
				if (step_q == ssvf_pkg::FILT_LAST) begin
					state_d = ssvf_pkg::ST_OUT;
				end
			end
			ssvf_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = ssvf_pkg::ST_IDLE;
				end
			end
			default: state_d = ssvf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.mac = ssvf_pkg::MAC_IDLE;
		cmd.load_in = 1'b0;
		cmd.load_out = 1'b0;
		cmd.commit_wgt = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ssvf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_in = in_valid;
			end
			ssvf_pkg::ST_WGT: begin
				cmd.mac = ssvf_pkg::wgt_cmd(step_q);
				cmd.commit_wgt = (step_q == ssvf_pkg::WGT_LAST);
			end
			ssvf_pkg::ST_FILT: cmd.mac = ssvf_pkg::filt_cmd(step_q);
			ssvf_pkg::ST_OUT: cmd.load_out = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssvf_pkg::ST_IDLE;
			step_q <= '0;
			dirty_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if (status.cfg_write) begin
				dirty_q <= 1'b1;
			end else if (cmd.commit_wgt) begin
				dirty_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/stereo_state_variable_filter.sv -----
// Top level of the stereo trapezoidal state variable filter: register port,
// controller and datapath. Depends on ssvf_pkg, ssvf_ctrl and ssvf_datapath.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    left_in, right_in
//   output    out        out_valid / out_stall  left_out, right_out
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// One word at a time. A filtered word runs the MAC steps and then the output
// load, which waits while the output is stalled, before out_valid shows; a new
// word is taken only once the block is back in idle. The seven multiplies per
// lane share that lane's one multiplier. The first filtered word after any
// register write first rebuilds the mix weights. A bypassed word skips the MAC
// steps and goes straight to the output load. Reset clears control and
// integrators. A stalled output word holds while the next input word is taken
// and computed.
module stereo_state_variable_filter #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_FRAC_BITS = 20,
	parameter int CHANNEL_COUNT = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       left_in,
	input  logic signed [SAMPLE_BITS-1:0]       right_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       left_out,
	output logic signed [SAMPLE_BITS-1:0]       right_out,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ssvf_pkg::ADDR_W-1:0]         paddr,
	input  logic [ssvf_pkg::DATA_W-1:0]         pwdata,
	output logic [ssvf_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	// Unity and two in coefficient format, clamped to the register width.
	localparam logic signed [ssvf_pkg::REG_W-1:0] REG_MAX = {1'b0, {(ssvf_pkg::REG_W-1){1'b1}}};
	localparam logic signed [ssvf_pkg::REG_W-1:0] ONE_RST =
		(COEF_FRAC_BITS >= ssvf_pkg::REG_W - 1) ? REG_MAX :
		ssvf_pkg::REG_W'(64'sd1 <<< COEF_FRAC_BITS);
	localparam logic signed [ssvf_pkg::REG_W-1:0] TWO_RST =
		(COEF_FRAC_BITS >= ssvf_pkg::REG_W - 2) ? REG_MAX :
		ssvf_pkg::REG_W'(64'sd2 <<< COEF_FRAC_BITS);

	logic                               bypass_q;
	logic [3:0]                         mode_q;
	logic signed [ssvf_pkg::REG_W-1:0]  coef_a1_q, coef_a2_q, coef_a3_q;
	logic signed [ssvf_pkg::REG_W-1:0]  damping_q, amplitude_q;
	logic                               cfg_write;
	ssvf_pkg::reg_idx_t                 reg_idx;
	ssvf_pkg::ctrl_status_t             status;
	ssvf_pkg::dp_cmd_t                  cmd;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx = ssvf_pkg::reg_idx_t'(paddr[ssvf_pkg::ADDR_W-1:2]);

	// User must change registers only between words (unenforced); datapath reads them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b1;
			mode_q <= ssvf_pkg::MODE_LOWPASS;
			coef_a1_q <= ONE_RST;
			coef_a2_q <= '0;
			coef_a3_q <= '0;
			damping_q <= TWO_RST;
			amplitude_q <= ONE_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				ssvf_pkg::REG_BYPASS:    bypass_q <= pwdata[0];
				ssvf_pkg::REG_MODE:      mode_q <= pwdata[3:0];
				ssvf_pkg::REG_COEF_A1:   coef_a1_q <= pwdata[ssvf_pkg::REG_W-1:0];
				ssvf_pkg::REG_COEF_A2:   coef_a2_q <= pwdata[ssvf_pkg::REG_W-1:0];
				ssvf_pkg::REG_COEF_A3:   coef_a3_q <= pwdata[ssvf_pkg::REG_W-1:0];
				ssvf_pkg::REG_DAMPING:   damping_q <= pwdata[ssvf_pkg::REG_W-1:0];
				ssvf_pkg::REG_AMPLITUDE: amplitude_q <= pwdata[ssvf_pkg::REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back raw register bits, zero-filled above.
	always_comb begin
		case (reg_idx)
			ssvf_pkg::REG_BYPASS:    prdata = ssvf_pkg::DATA_W'(bypass_q);
			ssvf_pkg::REG_MODE:      prdata = ssvf_pkg::DATA_W'(mode_q);
			ssvf_pkg::REG_COEF_A1:   prdata = ssvf_pkg::DATA_W'(unsigned'(coef_a1_q));
			ssvf_pkg::REG_COEF_A2:   prdata = ssvf_pkg::DATA_W'(unsigned'(coef_a2_q));
			ssvf_pkg::REG_COEF_A3:   prdata = ssvf_pkg::DATA_W'(unsigned'(coef_a3_q));
			ssvf_pkg::REG_DAMPING:   prdata = ssvf_pkg::DATA_W'(unsigned'(damping_q));
			ssvf_pkg::REG_AMPLITUDE: prdata = ssvf_pkg::DATA_W'(unsigned'(amplitude_q));
			default:                 prdata = '0;
		endcase
	end

	// Any write marks the mix weights stale; the controller rebuilds them.
	assign status.bypass = bypass_q;
	assign status.cfg_write = cfg_write;

	ssvf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cmd(cmd)
	);

	ssvf_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.bypass(bypass_q),
		.mode(mode_q),
		.coef_a1(coef_a1_q),
		.coef_a2(coef_a2_q),
		.coef_a3(coef_a3_q),
		.damping(damping_q),
		.amplitude(amplitude_q),
		.left_in(left_in),
		.right_in(right_in),
		.left_out(left_out),
		.right_out(right_out)
	);

endmodule

// ----- src/ssvf_checker.sv -----
// Port-level checks for the stereo state variable filter, bound to the top level.
// Depends on stereo_state_variable_filter's ports only.
module ssvf_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [SAMPLE_BITS-1:0] left_out,
	input logic [SAMPLE_BITS-1:0] right_out
);

	// one word in flight: block input right after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in flight");

	// no result can appear in the cycle right after acceptance
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(left_out) && $stable(right_out)))
		else $error("output word changed while stalled");

endmodule

bind stereo_state_variable_filter ssvf_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_ssvf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.left_out(left_out),
	.right_out(right_out)
);
